[rtl/lcis_pkg.sv]
package lcis_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int LCP_W       = 32;
   localparam int POS_W       = 32;
   localparam int ID_W        = 16;

   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LCP_W-1:0]  lcp_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [ID_W-1:0]   id_type;

   typedef struct packed {
      pos_type start;
      lcp_type lcp;
   } stack_entry_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic push_prev;
      logic push_saved;
      logic set_top_lcp;
      logic start;
      logic clear_all;
      logic pop;
      logic load_top;
      logic read_popped;
      logic init_saved;
      logic save_start;
      logic max_to_lcp;
      logic set_color;
      logic flush_begin;
      logic flush_read;
      logic flush_emit;
      logic flush_end;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic started;
      logic lcp_zero;
      logic lcp_gt_top;
      logic lcp_lt_top;
      logic lcp_gt_max;
      logic count_nz;
      logic color_diff;
      logic flush_last;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/lcis_if.sv]
interface lcis_req_if;
   import lcis_pkg::*;
   logic    valid;
   logic    ready;
   lcp_type lcp_length;
   id_type  seq_id;
   modport source (output valid, output lcp_length, output seq_id, input ready);
   modport sink (input valid, input lcp_length, input seq_id, output ready);
endinterface

interface lcis_rsp_if;
   import lcis_pkg::*;
   logic    valid;
   logic    ready;
   pos_type start_pos;
   lcp_type interval_lcp;
   logic    last;
   logic    overflow;
   modport source (output valid, output start_pos, output interval_lcp, output last,
                   output overflow, input ready);
   modport sink (input valid, input start_pos, input interval_lcp, input last,
                 input overflow, output ready);
endinterface

interface lcis_csr_if;
   import lcis_pkg::*;
   logic   valid;
   logic   ready;
   id_type reference_id;
   modport source (output valid, output reference_id, input ready);
   modport sink (input valid, input reference_id, output ready);
endinterface

[rtl/lcis_ram.sv]
module lcis_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lcis_dpath.sv]
module lcis_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  lcis_pkg::ctrl_cmd_type cmd,
   output lcis_pkg::dp_status_type status,
   input  lcis_pkg::lcp_type      req_lcp_length,
   input  lcis_pkg::id_type       req_seq_id,
   input  logic                   csr_valid,
   input  lcis_pkg::id_type       csr_reference_id,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lcis_pkg::pos_type      rsp_start_pos,
   output lcis_pkg::lcp_type      rsp_interval_lcp,
   output logic                   rsp_last,
   output logic                   rsp_overflow
);
   import lcis_pkg::*;

   lcp_type         lcp_ff, lcp_in;
   logic            color_ff, color_in;
   pos_type         prev_ff, prev_in;
   pos_type         position_ff, position_in;
   id_type          ref_id_ff, ref_id_in;
   count_type       count_ff, count_in;
   lcp_type         top_ff, top_in;
   lcp_type         max_ff, max_in;
   logic            color_cur_ff, color_cur_in;
   logic            started_ff, started_in;
   logic            ovf_ff, ovf_in;
   pos_type         saved_ff, saved_in;
   count_type       idx_ff, idx_in;
   logic            out_valid_ff, out_valid_in;
   pos_type         out_start_ff, out_start_in;
   lcp_type         out_lcp_ff, out_lcp_in;
   logic            out_last_ff, out_last_in;
   logic            out_ovf_ff, out_ovf_in;

   logic            push;
   logic            full;
   logic            wr_en;
   logic            rd_en;
   addr_type        rd_addr;
   count_type       below_cnt;
   count_type       idx_next;
   stack_entry_type wr_entry;
   stack_entry_type rd_entry;

   assign push      = cmd.push_prev | cmd.push_saved;
   assign full      = (count_ff >= count_type'(STACK_DEPTH));
   assign wr_en     = push & ~full;
   assign below_cnt = count_ff - count_type'(2);
   assign idx_next  = idx_ff + count_type'(1);

   assign wr_entry.start = cmd.push_prev ? prev_ff : saved_ff;
   assign wr_entry.lcp   = lcp_ff;

   assign rd_en = cmd.pop | cmd.read_popped | cmd.flush_read;

   always_comb begin
      if (cmd.pop) begin
         rd_addr = below_cnt[ADDR_W-1:0];
      end else if (cmd.read_popped) begin
         rd_addr = count_ff[ADDR_W-1:0];
      end else begin
         rd_addr = idx_ff[ADDR_W-1:0];
      end
   end

   lcis_ram #(
      .WIDTH ($bits(stack_entry_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign status.started    = started_ff;
   assign status.lcp_zero   = (lcp_ff == '0);
   assign status.lcp_gt_top = (lcp_ff > top_ff);
   assign status.lcp_lt_top = (lcp_ff < top_ff);
   assign status.lcp_gt_max = (lcp_ff > max_ff);
   assign status.count_nz   = (count_ff != '0);
   assign status.color_diff = (color_ff != color_cur_ff);
   assign status.flush_last = (idx_next == count_ff);
   assign status.out_free   = ~out_valid_ff | rsp_ready;

   always_comb begin
      lcp_in       = lcp_ff;
      color_in     = color_ff;
      prev_in      = prev_ff;
      position_in  = position_ff;
      ref_id_in    = ref_id_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      max_in       = max_ff;
      color_cur_in = color_cur_ff;
      started_in   = started_ff;
      ovf_in       = ovf_ff;
      saved_in     = saved_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_start_in = out_start_ff;
      out_lcp_in   = out_lcp_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      if (csr_valid) begin
         ref_id_in = csr_reference_id;
      end

      if (cmd.accept) begin
         lcp_in      = req_lcp_length;
         color_in    = (req_seq_id == ref_id_ff);
         prev_in     = position_ff - pos_type'(1);
         position_in = position_ff + pos_type'(1);
      end

      // stack count
      if (cmd.clear_all || cmd.flush_end) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + count_type'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - count_type'(1);
      end
      if (push && full) begin
         ovf_in = 1'b1;
      end

      // top lcp
      if (cmd.clear_all) begin
         top_in = '0;
      end else if (cmd.set_top_lcp) begin
         top_in = lcp_ff;
      end else if (cmd.load_top) begin
         top_in = status.count_nz ? rd_entry.lcp : '0;
      end

      // max common lcp
      if (cmd.clear_all) begin
         max_in = '0;
      end else if (cmd.max_to_lcp) begin
         max_in = lcp_ff;
      end else if (cmd.flush_emit) begin
         max_in = rd_entry.lcp;
      end

      if (cmd.set_color) begin
         color_cur_in = color_ff;
      end
      if (cmd.start) begin
         started_in = 1'b1;
      end

      if (cmd.init_saved) begin
         saved_in = prev_ff;
      end else if (cmd.save_start) begin
         saved_in = rd_entry.start;
      end

      if (cmd.flush_begin) begin
         idx_in = '0;
      end else if (cmd.flush_emit) begin
         idx_in = idx_next;
      end

      if (cmd.flush_emit) begin
         out_valid_in = 1'b1;
         out_start_in = rd_entry.start;
         out_lcp_in   = rd_entry.lcp;
         out_last_in  = status.flush_last;
         out_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         ref_id_ff    <= '0;
         count_ff     <= '0;
         top_ff       <= '0;
         max_ff       <= '0;
         color_cur_ff <= 1'b0;
         started_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         ref_id_ff    <= ref_id_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         max_ff       <= max_in;
         color_cur_ff <= color_cur_in;
         started_ff   <= started_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lcp_ff       <= lcp_in;
      color_ff     <= color_in;
      prev_ff      <= prev_in;
      saved_ff     <= saved_in;
      out_start_ff <= out_start_in;
      out_lcp_ff   <= out_lcp_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_start_pos    = out_start_ff;
   assign rsp_interval_lcp = out_lcp_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_overflow     = out_ovf_ff;

endmodule

[rtl/lcis_ctrl.sv]
module lcis_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lcis_pkg::dp_status_type status,
   output lcis_pkg::ctrl_cmd_type  cmd
);
   import lcis_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_POP    = 4'd2;
   localparam logic [3:0] S_POPW   = 4'd3;
   localparam logic [3:0] S_STARTW = 4'd4;
   localparam logic [3:0] S_FIN    = 4'd5;
   localparam logic [3:0] S_CHECK  = 4'd6;
   localparam logic [3:0] S_FREAD  = 4'd7;
   localparam logic [3:0] S_FWAIT  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       popped_ff, popped_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      popped_in = popped_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!status.started) begin
               if (!status.lcp_zero) begin
                  cmd.push_prev   = 1'b1;
                  cmd.set_top_lcp = 1'b1;
                  cmd.start       = 1'b1;
                  cmd.set_color   = 1'b1;
               end
               state_in = S_IDLE;
            end else if (status.lcp_zero) begin
               cmd.clear_all = 1'b1;
               cmd.set_color = 1'b1;
               state_in      = S_IDLE;
            end else if (status.lcp_gt_top) begin
               cmd.push_prev   = 1'b1;
               cmd.set_top_lcp = 1'b1;
               state_in        = S_CHECK;
            end else if (status.lcp_lt_top) begin
               cmd.init_saved = 1'b1;
               popped_in      = 1'b0;
               state_in       = S_POP;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_POP: begin
            if (status.count_nz && status.lcp_lt_top) begin
               cmd.pop   = 1'b1;
               popped_in = 1'b1;
               state_in  = S_POPW;
            end else if (popped_ff) begin
               cmd.read_popped = 1'b1;
               state_in        = S_STARTW;
            end else begin
               state_in = S_FIN;
            end
         end
         S_POPW: begin
            cmd.load_top = 1'b1;
            state_in     = S_POP;
         end
         S_STARTW: begin
            cmd.save_start = 1'b1;
            state_in       = S_FIN;
         end
         S_FIN: begin
            if (status.lcp_gt_max) begin
               cmd.push_saved = status.lcp_gt_top;
            end else begin
               cmd.max_to_lcp = 1'b1;
            end
            cmd.set_top_lcp = 1'b1;
            state_in        = S_CHECK;
         end
         S_CHECK: begin
            if (status.color_diff && status.count_nz) begin
               cmd.flush_begin = 1'b1;
               state_in        = S_FREAD;
            end else begin
               cmd.set_color = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FREAD: begin
            cmd.flush_read = 1'b1;
            state_in       = S_FWAIT;
         end
         S_FWAIT: begin
            if (status.out_free) begin
               cmd.flush_emit = 1'b1;
               if (status.flush_last) begin
                  cmd.flush_end = 1'b1;
                  cmd.set_color = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_FREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         popped_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         popped_ff <= popped_in;
      end
   end

endmodule

[rtl/colored_lcp_interval_stack_unit.sv]
// sequence: a leading zero or a zero lcp is decided and done; a push or an equal lcp
// goes on to the color check; a smaller lcp first pops while below the top, restores a
// popped start and pushes it or lowers the max; a color change then emits the stacked
// intervals one by one as the result register is free; one item is handled at a time,
// and a new item is accepted only in idle, once the last one is through
// reset: synchronous, active high; clears control and counters, stack memory not cleared
module colored_lcp_interval_stack_unit (
   input logic        clock,
   input logic        reset,
   lcis_req_if.sink   req_ch,
   lcis_rsp_if.source rsp_ch,
   lcis_csr_if.sink   csr_ch
);
   import lcis_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // reference id register takes a write at any time
   assign csr_ch.ready = 1'b1;

   // sequencer: walks the push, pop loop and flush for each item
   lcis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: interval stack memory, top/max registers, result register
   lcis_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_lcp_length   (req_ch.lcp_length),
      .req_seq_id       (req_ch.seq_id),
      .csr_valid        (csr_ch.valid),
      .csr_reference_id (csr_ch.reference_id),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_start_pos    (rsp_ch.start_pos),
      .rsp_interval_lcp (rsp_ch.interval_lcp),
      .rsp_last         (rsp_ch.last),
      .rsp_overflow     (rsp_ch.overflow)
   );

endmodule

[rtl/lcis_checker.sv]
module lcis_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input lcis_pkg::pos_type        rsp_start_pos,
   input lcis_pkg::lcp_type        rsp_interval_lcp,
   input logic                     rsp_last,
   input logic                     rsp_overflow
);
   import lcis_pkg::*;

   logic seen_ovf_ff, seen_ovf_in;

   assign seen_ovf_in = seen_ovf_ff | (rsp_valid & rsp_ready & rsp_overflow);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ovf_ff <= 1'b0;
      end else begin
         seen_ovf_ff <= seen_ovf_in;
      end
   end

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_pos)
         && $stable(rsp_interval_lcp) && $stable(rsp_last) && $stable(rsp_overflow))
      else $error("stalled result changed");

   // only nonzero lcp intervals are ever stacked
   a_lcp_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_interval_lcp != '0)
      else $error("flushed interval with zero lcp");

   // overflow flag is sticky across results
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ovf_ff |-> rsp_overflow)
      else $error("overflow flag dropped");

endmodule

bind colored_lcp_interval_stack_unit lcis_checker u_lcis_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_start_pos    (rsp_ch.start_pos),
   .rsp_interval_lcp (rsp_ch.interval_lcp),
   .rsp_last         (rsp_ch.last),
   .rsp_overflow     (rsp_ch.overflow)
);

[dv/colored_lcp_interval_stack_unit_tb.sv]
module colored_lcp_interval_stack_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcis_pkg::*;

   // cycle budget for the whole run, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200_000;
   // quiet cycles after the last result, covers a full pop-down of the stack
   localparam int SETTLE_CYCLES = 300;
   // length of the forced result-side hold-off
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      lcp_type lcp;
      id_type  id;
   } lcp_item_type;

   typedef struct {
      pos_type start;
      lcp_type lcp;
      logic    last;
      logic    ovf;
   } interval_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcis_req_if req_ch();
   lcis_rsp_if rsp_ch();
   lcis_csr_if csr_ch();

   colored_lcp_interval_stack_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // items waiting to be offered, and intervals waiting to come out
   lcp_item_type     pending_items[$];
   interval_rec_type expected_intervals[$];

   // predictor state
   pos_type sk_start [STACK_DEPTH];
   lcp_type sk_lcp   [STACK_DEPTH];
   int      sk_count;
   lcp_type top_lcp;
   lcp_type max_lcp;
   bit      cur_color;
   pos_type pos_k;
   bit      opened;
   bit      ovf_flag;
   id_type  ref_id;

   // run statistics
   int items_done;
   int intervals_checked;
   int flushes_seen;
   int csr_writes;
   int mismatch_count;
   int cycle_count;

   // hold-off request from the sequencer, counted down in its own process
   logic hold_req;
   logic hold_done;
   int   hold_left;

   // a push into a full stack is dropped and only marks overflow
   function automatic void stack_push(pos_type s, lcp_type l);
      if (sk_count >= STACK_DEPTH) begin
         ovf_flag = 1'b1;
      end else begin
         sk_start[sk_count] = s;
         sk_lcp[sk_count]   = l;
         sk_count++;
      end
   endfunction

   // advance the predictor by one accepted item, queue the intervals it flushes
   function automatic void compute_intervals(lcp_type lcp, id_type id);
      bit               color;
      pos_type          prev;
      pos_type          s;
      interval_rec_type iv;
      color = (id == ref_id);
      prev  = pos_k - 1;
      if (!opened) begin
         // leading zero lcp items only advance the position
         if (lcp != 0) begin
            stack_push(prev, lcp);
            top_lcp   = lcp;
            cur_color = color;
            opened    = 1'b1;
         end
      end else if (lcp == 0) begin
         sk_count  = 0;
         cur_color = color;
         max_lcp   = 0;
         top_lcp   = 0;
      end else begin
         if (lcp > top_lcp) begin
            stack_push(prev, lcp);
            top_lcp = lcp;
         end else if (lcp < top_lcp) begin
            s = prev;
            while (sk_count > 0 && lcp < top_lcp) begin
               sk_count--;
               s       = sk_start[sk_count];
               top_lcp = (sk_count > 0) ? sk_lcp[sk_count-1] : '0;
            end
            // reopen with the deepest popped start, or lower the common max
            if (lcp > max_lcp) begin
               if (lcp > top_lcp) stack_push(s, lcp);
            end else begin
               max_lcp = lcp;
            end
            top_lcp = lcp;
         end
         // a color change flushes the whole stack bottom first
         if (color != cur_color) begin
            for (int i = 0; i < sk_count; i++) begin
               iv.start = sk_start[i];
               iv.lcp   = sk_lcp[i];
               iv.last  = (i + 1 == sk_count);
               iv.ovf   = ovf_flag;
               expected_intervals.push_back(iv);
               max_lcp = sk_lcp[i];
            end
            sk_count  = 0;
            cur_color = color;
         end
      end
      pos_k = pos_k + 1;
   endfunction

   // --------------------------------------------------------------------------
   // driver: offers queued items, random gap after each accepted one
   // --------------------------------------------------------------------------
   int unsigned  req_gap;
   bit           req_idle_on;
   lcp_item_type req_cur;

   always @(posedge clock) begin : req_driver
      bit busy;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap     = 0;
         req_idle_on = 1'b1;
      end else begin
         busy = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            compute_intervals(req_cur.lcp, req_cur.id);
            items_done++;
            busy = 1'b0;
            // switch between idling and back-to-back stretches now and then
            if ($urandom_range(0, 19) == 0) req_idle_on = !req_idle_on;
            req_gap = req_idle_on ? $urandom_range(0, 5) : 0;
         end
         if (!busy) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (pending_items.size() != 0) begin
               req_cur = pending_items[0];
               pending_items.delete(0);
               req_ch.valid      <= 1'b1;
               req_ch.lcp_length <= req_cur.lcp;
               req_ch.seq_id     <= req_cur.id;
               busy = 1'b1;
            end
         end
         // valid only drops when nothing new was put up this edge
         if (!busy) req_ch.valid <= 1'b0;
      end
   end

   // --------------------------------------------------------------------------
   // long result-side hold-off, so the block backs up and stalls its input
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // --------------------------------------------------------------------------
   // monitor: takes intervals, compares with the oldest expectation
   // --------------------------------------------------------------------------
   int unsigned rsp_stall;
   bit          rsp_idle_on;

   always @(posedge clock) begin : rsp_monitor
      interval_rec_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall   = 0;
         rsp_idle_on = 1'b1;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_intervals.size() == 0) begin
               if (mismatch_count < 10)
                  $display("[%0t] unexpected interval start=%h lcp=%h last=%b ovf=%b",
                           $realtime, rsp_ch.start_pos, rsp_ch.interval_lcp,
                           rsp_ch.last, rsp_ch.overflow);
               mismatch_count++;
            end else begin
               want = expected_intervals[0];
               expected_intervals.delete(0);
               if (rsp_ch.start_pos !== want.start || rsp_ch.interval_lcp !== want.lcp ||
                   rsp_ch.last !== want.last || rsp_ch.overflow !== want.ovf) begin
                  if (mismatch_count < 10)
                     $display("[%0t] interval mismatch: exp start=%h lcp=%h last=%b ovf=%b",
                              $realtime, want.start, want.lcp, want.last, want.ovf,
                              " got start=%h lcp=%h last=%b ovf=%b",
                              rsp_ch.start_pos, rsp_ch.interval_lcp,
                              rsp_ch.last, rsp_ch.overflow);
                  mismatch_count++;
               end
            end
            intervals_checked++;
            if (rsp_ch.last === 1'b1) flushes_seen++;
            if ($urandom_range(0, 19) == 0) rsp_idle_on = !rsp_idle_on;
            rsp_stall = rsp_idle_on ? $urandom_range(0, 5) : 0;
         end else if (rsp_stall != 0) begin
            rsp_stall--;
         end
         rsp_ch.ready <= (rsp_stall == 0) && (hold_left == 0);
      end
   end

   // hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d intervals still expected",
                  cycle_count, expected_intervals.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------------
   function automatic void add_item(lcp_type lcp, id_type id);
      lcp_item_type it;
      it.lcp = lcp;
      it.id  = id;
      pending_items.push_back(it);
   endfunction

   // an id of the requested color under the current reference id
   function automatic id_type pick_id(bit color);
      id_type x;
      if (color) return ref_id;
      do x = id_type'($urandom); while (x == ref_id);
      return x;
   endfunction

   // wait until every item is in and every interval is out, then let the
   // block finish any pops that produce nothing
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_intervals.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reference(id_type v);
      @(posedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.reference_id <= v;
      do @(posedge clock); while (!csr_ch.ready);
      ref_id = v;
      csr_writes++;
      csr_ch.valid <= 1'b0;
   endtask

   // well-formed lcp walk: climbs, descents, plateaus, occasional zero breaks
   // and huge values, color flipping now and then; noise percent is raw items
   task automatic queue_walk(int n, int noise);
      lcp_type base;
      lcp_type level;
      bit      color;
      int      r;
      base  = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FF00) : '0;
      level = $urandom_range(1, 8);
      color = ($urandom_range(0, 1) == 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < noise) begin
            add_item($urandom, id_type'($urandom));
         end else begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 5) == 0) color = !color;
            if (r < 40) begin
               level = (level < 196) ? level + $urandom_range(1, 4) : level;
            end else if (r < 75) begin
               level = (level > 5) ? level - $urandom_range(1, 5) : 32'd1;
            end else if (r < 85) begin
               // plateau, lcp equal to the top
            end else if (r < 92) begin
               add_item('0, pick_id(color));
               continue;
            end else begin
               add_item($urandom | 32'd1, pick_id(color));
               continue;
            end
            add_item(base + level, pick_id(color));
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // sequencer
   // --------------------------------------------------------------------------
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.lcp_length   = '0;
      req_ch.seq_id       = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.reference_id = '0;
      hold_req            = 1'b0;
      sk_count  = 0;
      top_lcp   = '0;
      max_lcp   = '0;
      cur_color = 1'b0;
      pos_k     = '0;
      opened    = 1'b0;
      ovf_flag  = 1'b0;
      ref_id    = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass, reference id at its lower extreme
      write_reference(16'h0000);
      add_item(32'd0, 16'h0000);          // leading zeros are skipped
      add_item(32'd0, 16'hFFFF);
      add_item(32'd4, 16'h0000);          // first nonzero opens an interval
      add_item(32'hFFFF_FFFF, 16'h0000);  // largest lcp
      add_item(32'hFFFF_FFFF, 16'h0000);  // equal lcp, no change
      add_item(32'd10, 16'h0000);         // pop then reopen with popped start
      add_item(32'd2, 16'h0000);          // pop two, reopen at deepest start
      add_item(32'd8, 16'h0000);
      add_item(32'd1, 16'h1234);          // color change flushes one interval
      add_item(32'd3, 16'h0005);
      add_item(32'd6, 16'h0005);
      add_item(32'd6, 16'h0007);          // same color, other id, equal lcp
      add_item(32'd1, 16'h0000);          // drop to max common, empty flush
      add_item(32'd5, 16'h0000);
      add_item(32'd0, 16'h0000);          // zero lcp clears everything
      add_item(32'd9, 16'h0000);
      add_item(32'd12, 16'h0000);
      add_item(32'd11, 16'h0000);
      add_item(32'd20, 16'h0000);
      add_item(32'd3, 16'hFFFF);          // full pop-down then flush
      add_item(32'd2, 16'h0001);          // below max common on empty stack
      add_item(32'd7, 16'h0001);
      add_item(32'd9, 16'h8000);
      add_item(32'd5, 16'h0000);
      add_item(32'd8, 16'h0000);
      add_item(32'd10, 16'h0000);
      add_item(32'd12, 16'h0002);         // multi-interval flush
      wait_drained();

      // reference id at its upper extreme
      write_reference(16'hFFFF);
      queue_walk(6, 10);
      wait_drained();

      // receiver holds off for a long stretch while items keep coming
      write_reference(id_type'($urandom));
      hold_req <= 1'b1;
      // a sure flush right at the start of the hold-off
      add_item('0, pick_id(1'b1));
      add_item(32'd5, pick_id(1'b1));
      add_item(32'd6, pick_id(1'b0));
      queue_walk(8, 5);
      wait_drained();

      write_reference(id_type'($urandom));
      queue_walk(6, 20);
      wait_drained();

      // climb past the stack depth, then flush a full stack with overflow set
      write_reference(16'h8001);
      add_item('0, pick_id(1'b1));
      for (int i = 1; i <= STACK_DEPTH + 2; i++) add_item(lcp_type'(i), pick_id(1'b1));
      add_item(lcp_type'(STACK_DEPTH + 10), pick_id(1'b0));
      wait_drained();

      $display("run covered %0d items, %0d intervals in %0d flushes, %0d reference writes",
               items_done, intervals_checked, flushes_seen, csr_writes);
      $display("stack overflow reached: %0d, mismatches: %0d", ovf_flag, mismatch_count);
      if (mismatch_count == 0 && expected_intervals.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
